// ===== src/lsne_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lsne_pkg;
    localparam int CHANNELS = 8;
    localparam int SAMPLE_BITS = 12;
    localparam int LEVEL_W = 7;
    localparam int ERR_W = 20;
    localparam int SPAN_W = 12;
    localparam int LOST_W = 10;
    localparam int LIMIT_W = 10;
    localparam int CFG_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        OP_NORMAL = 2'd0,
        OP_WHITE  = 2'd1,
        OP_BLACK  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_DIV,
        ST_ERR,
        ST_FILT,
        ST_OUT
    } bk_state_t;
endpackage
`default_nettype wire

// ===== src/lsne_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface lsne_in_if #(parameter int SAMPLE_BITS = lsne_pkg::SAMPLE_BITS);
    logic valid;
    logic ready;
    logic [1:0] operation;
    logic [SAMPLE_BITS-1:0] raw_ch0, raw_ch1, raw_ch2, raw_ch3;
    logic [SAMPLE_BITS-1:0] raw_ch4, raw_ch5, raw_ch6, raw_ch7;
    modport source (output valid, operation, raw_ch0, raw_ch1, raw_ch2, raw_ch3,
        raw_ch4, raw_ch5, raw_ch6, raw_ch7, input ready);
    modport sink (input valid, operation, raw_ch0, raw_ch1, raw_ch2, raw_ch3,
        raw_ch4, raw_ch5, raw_ch6, raw_ch7, output ready);
endinterface

interface lsne_out_if;
    logic valid;
    logic ready;
    logic [6:0] level_ch0, level_ch1, level_ch2, level_ch3;
    logic [6:0] level_ch4, level_ch5, level_ch6, level_ch7;
    logic lost_flag;
    logic signed [19:0] filtered_error;
    modport source (output valid, level_ch0, level_ch1, level_ch2, level_ch3,
        level_ch4, level_ch5, level_ch6, level_ch7, lost_flag, filtered_error,
        input ready);
    modport sink (input valid, level_ch0, level_ch1, level_ch2, level_ch3,
        level_ch4, level_ch5, level_ch6, level_ch7, lost_flag, filtered_error,
        output ready);
endinterface
`default_nettype wire

// ===== src/line_sensor_normalize_and_error_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir   Payload
// in_ch     in    operation, raw_ch0..raw_ch7
// out_ch    out   level_ch0..level_ch7, lost_flag, filtered_error
// cfg       in    cfg_we, cfg_index, cfg_data
// A normal word waits in the queue and is popped; each nonzero channel
// level is then divided on the shared 32 bit serial divider, followed by the
// line error division, clamp and filter unless the line is lost; the lost
// flag is set last. A zero channel skips the divider; capture words skip it.
// Reset clears references, levels and the filter. A two-entry queue keeps
// accepting while the engine or a stalled output holds.
module line_sensor_normalize_and_error_unit #(
    parameter int SAMPLE_BITS = lsne_pkg::SAMPLE_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lsne_in_if.sink    in_ch,
    lsne_out_if.source out_ch,
    input  wire logic                           cfg_we,
    input  wire logic [lsne_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lsne_pkg::CFG_W-1:0]     cfg_data
);
    logic [lsne_pkg::SPAN_W-1:0] min_span_reg;
    logic [lsne_pkg::LOST_W-1:0] lost_reg;
    logic [lsne_pkg::LIMIT_W-1:0] limit_reg;
    logic q_valid, pop;
    logic [1:0] q_op;
    logic [lsne_pkg::CHANNELS*SAMPLE_BITS-1:0] q_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_span_reg <= 12'd8;
            lost_reg <= 10'd50;
            limit_reg <= 10'd500;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lsne_pkg::REG_MIN_SPAN: min_span_reg <= cfg_data;
                lsne_pkg::REG_LOST: lost_reg <= cfg_data[lsne_pkg::LOST_W-1:0];
                lsne_pkg::REG_LIMIT: limit_reg <= cfg_data[lsne_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    lsne_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .pop(pop),
        .q_valid(q_valid), .q_op(q_op), .q_raw(q_raw)
    );

    lsne_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_op(q_op), .q_raw(q_raw),
        .pop(pop), .min_span(min_span_reg), .lost_threshold(lost_reg),
        .error_limit(limit_reg), .out_ch(out_ch)
    );

    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.level_ch0 <= 7'd100 && out_ch.level_ch7 <= 7'd100))
        else $error("level above 100");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.filtered_error))
        else $error("result changed while stalled");
    a_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.level_ch0 == 7'd0 && out_ch.level_ch1 == 7'd0 &&
        out_ch.level_ch2 == 7'd0 && out_ch.level_ch3 == 7'd0 &&
        out_ch.level_ch4 == 7'd0 && out_ch.level_ch5 == 7'd0 &&
        out_ch.level_ch6 == 7'd0 && out_ch.level_ch7 == 7'd0 |-> out_ch.lost_flag)
        else $error("zero sum not flagged lost");
endmodule
`default_nettype wire

// ===== src/lsne_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle; unsigned operands.
module lsne_divider #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0] q_reg, q_next;
    logic [W-1:0] r_reg, r_next;
    logic [W-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [W+1:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = '0;
        done = 1'b0;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CW'(0))
            begin
                // All quotient bits are in; signal done and hold the result.
                done = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                trial = {1'b0, r_reg, q_reg[W-1]} - {2'b00, d_reg};
                if (!trial[W+1])
                begin
                    r_next = trial[W-1:0];
                    q_next = {q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    r_next = {r_reg[W-2:0], q_reg[W-1]};
                    q_next = {q_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule
`default_nettype wire

// ===== src/lsne_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Accepts words into a small queue; the back end pops them.
module lsne_front #(
    parameter int SAMPLE_BITS = lsne_pkg::SAMPLE_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lsne_in_if.sink   in_ch,
    input  wire logic pop,
    output logic      q_valid,
    output logic [1:0] q_op,
    output logic [lsne_pkg::CHANNELS*SAMPLE_BITS-1:0] q_raw
);
    localparam int IW = lsne_pkg::CHANNELS * SAMPLE_BITS + 2;
    logic [IW-1:0] mem_reg [lsne_pkg::QDEPTH];
    logic wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push;
    logic [IW-1:0] wdata;

    assign in_ch.ready = (cnt_reg != 2'(lsne_pkg::QDEPTH));
    assign push = in_ch.valid && in_ch.ready;
    assign wdata = {in_ch.raw_ch7, in_ch.raw_ch6, in_ch.raw_ch5, in_ch.raw_ch4,
        in_ch.raw_ch3, in_ch.raw_ch2, in_ch.raw_ch1, in_ch.raw_ch0, in_ch.operation};
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op = mem_reg[rp_reg][1:0];
    assign q_raw = mem_reg[rp_reg][IW-1:2];

    always_comb
    begin
        wp_next = wp_reg ^ push;
        rp_next = rp_reg ^ pop;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end
endmodule
`default_nettype wire

// ===== src/lsne_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequential engine: up to eight level divisions and at most one error division share one divider.
module lsne_back #(
    parameter int SAMPLE_BITS = lsne_pkg::SAMPLE_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire logic [1:0] q_op,
    input  wire logic [lsne_pkg::CHANNELS*SAMPLE_BITS-1:0] q_raw,
    output logic      pop,
    input  wire logic [lsne_pkg::SPAN_W-1:0]  min_span,
    input  wire logic [lsne_pkg::LOST_W-1:0]  lost_threshold,
    input  wire logic [lsne_pkg::LIMIT_W-1:0] error_limit,
    lsne_out_if.source out_ch
);
    localparam int CH = lsne_pkg::CHANNELS;
    localparam int DW = 32;
    // Reciprocal of five scaled by 2**24; exact for magnitudes below 2**22.
    localparam logic [21:0] FIFTH_MUL = 22'd3355444;

    lsne_pkg::bk_state_t st_reg, st_next;
    logic [SAMPLE_BITS-1:0] white_reg [CH];
    logic [SAMPLE_BITS-1:0] black_reg [CH];
    logic [6:0] lvl_reg [CH];
    logic signed [19:0] em_reg, em_next;
    logic [2:0] ch_reg, ch_next;
    logic [CH*SAMPLE_BITS-1:0] raw_reg;
    logic lost_reg, lost_next;
    logic neg_reg, neg_next;
    logic skip_reg, skip_next;
    logic signed [21:0] rawe_reg, rawe_next;
    logic ov_reg, ov_next;

    logic div_start, div_done;
    logic start_d_reg;
    logic [DW-1:0] div_a, div_b, div_q;
    logic [DW-1:0] div_a_reg, div_b_reg;

    lsne_divider #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(start_d_reg), .dividend(div_a_reg),
        .divisor(div_b_reg), .done(div_done), .quotient(div_q)
    );

    logic [SAMPLE_BITS-1:0] raw_c, wh_c, bk_c;
    logic signed [SAMPLE_BITS:0] den_c, num0_c;
    logic [SAMPLE_BITS-1:0] aden_c;
    logic [SAMPLE_BITS:0] anum0_c;
    logic lvl_zero_c;
    logic [9:0] sum_c;
    logic signed [10:0] diff_c;
    logic [9:0] adiff_c;
    logic [19:0] lim_c;
    logic [21:0] mag_c;
    logic signed [23:0] fnum_c;
    logic [23:0] afnum_c;
    logic [45:0] prod5_c;
    logic lost_c;

    function automatic logic [SAMPLE_BITS-1:0] q_raw_sel(
        input logic [CH*SAMPLE_BITS-1:0] v, input logic [2:0] k);
        q_raw_sel = v[k*SAMPLE_BITS +: SAMPLE_BITS];
    endfunction

    always_comb
    begin
        raw_c = q_raw_sel(raw_reg, ch_reg);
        wh_c = white_reg[ch_reg];
        bk_c = black_reg[ch_reg];
        den_c = $signed({1'b0, bk_c}) - $signed({1'b0, wh_c});
        num0_c = $signed({1'b0, raw_c}) - $signed({1'b0, wh_c});
        aden_c = den_c[SAMPLE_BITS] ? SAMPLE_BITS'(-den_c) : den_c[SAMPLE_BITS-1:0];
        anum0_c = num0_c[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-num0_c) : (SAMPLE_BITS+1)'(num0_c);
        lvl_zero_c = (aden_c == '0) || ({{(lsne_pkg::SPAN_W){1'b0}}, aden_c} <
            {{SAMPLE_BITS{1'b0}}, min_span}) || (num0_c == '0) ||
            (num0_c[SAMPLE_BITS] != den_c[SAMPLE_BITS]);
        sum_c = '0;
        for (int i = 0; i < CH; i++)
        begin
            sum_c = sum_c + 10'(lvl_reg[i]);
        end
        diff_c = $signed({1'b0, 10'(5 * lvl_reg[0] + 4 * lvl_reg[1])})
            - $signed({1'b0, 10'(5 * lvl_reg[7] + 4 * lvl_reg[6])});
        adiff_c = diff_c[10] ? 10'(-diff_c) : diff_c[9:0];
        lost_c = (sum_c == '0) || (sum_c < lost_threshold);
        lim_c = (error_limit > 10'd511) ? 20'd524287 : {error_limit, 10'd0};
        mag_c = rawe_reg[21] ? 22'(-rawe_reg) : 22'(rawe_reg);
        fnum_c = 24'(rawe_reg) * 24'sd4 + 24'(em_reg);
        afnum_c = fnum_c[23] ? 24'(-fnum_c) : 24'(fnum_c);
        prod5_c = 46'(afnum_c) * 46'(FIFTH_MUL);
    end

    logic lvl_we;
    logic [6:0] lvl_wd;

    always_comb
    begin
        st_next = st_reg;
        ch_next = ch_reg;
        em_next = em_reg;
        lost_next = lost_reg;
        neg_next = neg_reg;
        skip_next = skip_reg;
        rawe_next = rawe_reg;
        ov_next = ov_reg;
        pop = 1'b0;
        div_start = 1'b0;
        div_a = div_a_reg;
        div_b = div_b_reg;
        lvl_we = 1'b0;
        lvl_wd = '0;
        case (st_reg)
            lsne_pkg::ST_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    pop = 1'b1;
                    ch_next = '0;
                    st_next = (q_op == lsne_pkg::OP_NORMAL) ? lsne_pkg::ST_LEVEL
                        : lsne_pkg::ST_FILT;
                    skip_next = 1'b1;
                end
            end
            lsne_pkg::ST_LEVEL:
            begin
                if (!skip_reg && div_done)
                begin
                    lvl_we = 1'b1;
                    lvl_wd = (div_q > DW'(100)) ? 7'd100 : div_q[6:0];
                    ch_next = ch_reg + 3'd1;
                    skip_next = 1'b1;
                    if (ch_reg == 3'(CH - 1))
                    begin
                        st_next = lsne_pkg::ST_DIV;
                    end
                end
                else if (skip_reg)
                begin
                    if (lvl_zero_c)
                    begin
                        lvl_we = 1'b1;
                        lvl_wd = '0;
                        ch_next = ch_reg + 3'd1;
                        if (ch_reg == 3'(CH - 1))
                        begin
                            st_next = lsne_pkg::ST_DIV;
                        end
                    end
                    else
                    begin
                        div_a = DW'(anum0_c) * DW'(100);
                        div_b = DW'(aden_c);
                        div_start = 1'b1;
                        skip_next = 1'b0;
                    end
                end
            end
            lsne_pkg::ST_DIV:
            begin
                if (skip_reg)
                begin
                    if (lost_c)
                    begin
                        st_next = lsne_pkg::ST_FILT;
                    end
                    else
                    begin
                        neg_next = diff_c[10];
                        div_a = DW'(adiff_c) * DW'(358400);
                        div_b = DW'(sum_c);
                        div_start = 1'b1;
                        skip_next = 1'b0;
                    end
                end
                else if (div_done)
                begin
                    if (div_q > DW'(lim_c))
                    begin
                        rawe_next = neg_reg ? -22'sd0 - 22'(lim_c) : 22'(lim_c);
                    end
                    else
                    begin
                        rawe_next = neg_reg ? -$signed(22'(div_q)) : $signed(22'(div_q));
                    end
                    st_next = lsne_pkg::ST_ERR;
                end
            end
            lsne_pkg::ST_ERR:
            begin
                if (26'(mag_c) * 26'd7 < 26'd15360)
                begin
                    rawe_next = '0;
                end
                st_next = lsne_pkg::ST_OUT;
                skip_next = 1'b1;
            end
            lsne_pkg::ST_OUT:
            begin
                // Divide by five on the magnitude so the result truncates toward zero.
                em_next = fnum_c[23] ? -$signed(prod5_c[43:24]) : $signed(prod5_c[43:24]);
                st_next = lsne_pkg::ST_FILT;
            end
            lsne_pkg::ST_FILT:
            begin
                lost_next = lost_c;
                ov_next = 1'b1;
                st_next = lsne_pkg::ST_IDLE;
            end
            default:
            begin
                st_next = lsne_pkg::ST_IDLE;
            end
        endcase
        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= lsne_pkg::ST_IDLE;
            ov_reg <= 1'b0;
            em_reg <= '0;
            for (int i = 0; i < CH; i++)
            begin
                white_reg[i] <= '0;
                black_reg[i] <= '0;
                lvl_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            em_reg <= em_next;
            if (pop && q_op == lsne_pkg::OP_WHITE)
            begin
                for (int i = 0; i < CH; i++)
                begin
                    white_reg[i] <= q_raw[i*SAMPLE_BITS +: SAMPLE_BITS];
                end
            end
            if (pop && q_op == lsne_pkg::OP_BLACK)
            begin
                for (int i = 0; i < CH; i++)
                begin
                    black_reg[i] <= q_raw[i*SAMPLE_BITS +: SAMPLE_BITS];
                end
            end
            if (lvl_we)
            begin
                lvl_reg[ch_reg] <= lvl_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
        lost_reg <= lost_next;
        neg_reg <= neg_next;
        skip_reg <= skip_next;
        rawe_reg <= rawe_next;
        div_a_reg <= div_a;
        div_b_reg <= div_b;
        if (pop)
        begin
            raw_reg <= q_raw;
        end
    end

    // The divider operands are registered, so start is registered as well to match them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_d_reg <= 1'b0;
        end
        else
        begin
            start_d_reg <= div_start;
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.level_ch0 = lvl_reg[0];
    assign out_ch.level_ch1 = lvl_reg[1];
    assign out_ch.level_ch2 = lvl_reg[2];
    assign out_ch.level_ch3 = lvl_reg[3];
    assign out_ch.level_ch4 = lvl_reg[4];
    assign out_ch.level_ch5 = lvl_reg[5];
    assign out_ch.level_ch6 = lvl_reg[6];
    assign out_ch.level_ch7 = lvl_reg[7];
    assign out_ch.lost_flag = lost_reg;
    assign out_ch.filtered_error = em_reg;
endmodule
`default_nettype wire
